[rtl/core/hsfoc_pkg.sv]
package hsfoc_pkg;

    // Datapath widths.
    localparam int CURRENT_BITS = 12;
    localparam int FRAC_BITS    = 16;

    // Trigonometry constants, Q1.16.
    localparam logic signed [17:0] TRIG_ONE  = 18'sd65536;
    localparam logic signed [17:0] TRIG_HALF = 18'sd32768;
    localparam logic signed [17:0] TRIG_S60  = 18'sd56756;
    localparam logic [15:0] INV_SQRT3_Q16    = 16'd37837;
    localparam logic [11:0] THROTTLE_FULL    = 12'd4095;
    localparam logic [11:0] THROTTLE_HALF    = 12'd2047;

    // Configuration register indexes.
    localparam logic [1:0] REG_KP_D = 2'd0;
    localparam logic [1:0] REG_KI_D = 2'd1;
    localparam logic [1:0] REG_KP_Q = 2'd2;
    localparam logic [1:0] REG_KI_Q = 2'd3;

    localparam logic [2:0] SECTOR_KEEP = 3'd7;

    // Hall code to sector; codes 000 and 111 keep the previous sector.
    function automatic logic [2:0] hall_to_sector(input logic [2:0] code);
        logic [2:0] s;
        unique case (code)
            3'b001:  s = 3'd0;
            3'b101:  s = 3'd1;
            3'b100:  s = 3'd2;
            3'b110:  s = 3'd3;
            3'b010:  s = 3'd4;
            3'b011:  s = 3'd5;
            default: s = SECTOR_KEEP;
        endcase
        return s;
    endfunction

    function automatic logic signed [17:0] cos_of(input logic [2:0] sec);
        logic signed [17:0] c;
        unique case (sec)
            3'd1:    c = TRIG_HALF;
            3'd2:    c = -TRIG_HALF;
            3'd3:    c = -TRIG_ONE;
            3'd4:    c = -TRIG_HALF;
            3'd5:    c = TRIG_HALF;
            default: c = TRIG_ONE;
        endcase
        return c;
    endfunction

    function automatic logic signed [17:0] sin_of(input logic [2:0] sec);
        logic signed [17:0] s;
        unique case (sec)
            3'd1, 3'd2: s = TRIG_S60;
            3'd4, 3'd5: s = -TRIG_S60;
            default:    s = 18'sd0;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/hsfoc_mac.sv]
// Shared multiply unit: one signed product per cycle, registered.
module hsfoc_mac
    import hsfoc_pkg::*;
(
    input  logic                i_clk,
    input  logic signed [48:0]  i_a,
    input  logic signed [17:0]  i_b,
    output logic signed [66:0]  o_p
);

    logic signed [66:0] r_p;

    // The wide operand is split into a 31-bit low product plus a high product.
    logic signed [66:0] n_p;
    logic signed [17:0] a_hi;
    logic        [30:0] a_lo;
    logic signed [35:0] p_hi;
    logic signed [49:0] p_lo;
    always_comb begin
        a_hi = i_a[48:31];
        a_lo = i_a[30:0];
        p_hi = a_hi * i_b;
        p_lo = $signed({1'b0, a_lo}) * i_b;
        n_p  = (67'(p_hi) <<< 31) + 67'(p_lo);
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

[rtl/core/hall_sector_foc_current_loop.sv]
// Channel  | Direction | Handshake          | Payload
// input    | in        | i_valid / o_ready  | phase currents, hall code, throttle
// result   | out       | o_valid / i_ready  | v_alpha, v_beta, saturated
// config   | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// An accepted item walks 19 sequencer steps that share one multiplier, and its
// result is raised on o_valid when the last step ends.
// The block is ready again the cycle after the result is taken, so it takes no
// new item until then; while i_ready is low it stays busy.
// Reset is synchronous and active low and clears the sector and integrators
// and loads the default gains. Configuration writes take effect at once.
module hall_sector_foc_current_loop
    import hsfoc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CURRENT_BITS-1:0]  i_phase_a_current,
    input  logic [CURRENT_BITS-1:0]  i_phase_b_current,
    input  logic [2:0]               i_hall_code,
    input  logic [11:0]              i_throttle_count,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [31:0]       o_v_alpha,
    output logic signed [31:0]       o_v_beta,
    output logic                     o_saturated,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [15:0]              i_cfg_data
);

    localparam logic signed [48:0] INTEG_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] INTEG_MIN = -49'sh0_8000_0000_0000;
    localparam logic signed [66:0] V_MAX = 67'sd2147483647;
    localparam logic signed [66:0] V_MIN = -67'sd2147483648;

    // Sequencer codes.
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_IB   = 5'd1;   // beta numerator * 1/sqrt3
    localparam logic [4:0] S_ID0  = 5'd2;   // ia*c
    localparam logic [4:0] S_ID1  = 5'd3;   // ib*s
    localparam logic [4:0] S_IQ0  = 5'd4;   // ib*c
    localparam logic [4:0] S_IQ1  = 5'd5;   // ia*s
    localparam logic [4:0] S_EQ   = 5'd6;   // q current done
    localparam logic [4:0] S_INT  = 5'd7;   // integrators, kp_d*e_d
    localparam logic [4:0] S_PD1  = 5'd8;   // ki_d*integ_d
    localparam logic [4:0] S_PQ0  = 5'd9;   // kp_q*e_q
    localparam logic [4:0] S_PQ1  = 5'd10;  // ki_q*integ_q
    localparam logic [4:0] S_VQ   = 5'd11;  // q voltage done
    localparam logic [4:0] S_TH   = 5'd12;  // |vq|*thr
    localparam logic [4:0] S_DV0  = 5'd13;  // quotient estimate
    localparam logic [4:0] S_DV1  = 5'd14;  // quotient correction
    localparam logic [4:0] S_VA0  = 5'd15;  // vd*c
    localparam logic [4:0] S_VA1  = 5'd16;  // vq*s
    localparam logic [4:0] S_VB0  = 5'd17;  // vd*s
    localparam logic [4:0] S_VB1  = 5'd18;  // vq*c
    localparam logic [4:0] S_FIN  = 5'd19;
    localparam logic [4:0] S_OUT  = 5'd20;

    // Registers.
    logic [4:0]  r_state, n_state;
    logic [2:0]  r_sector;
    logic signed [47:0] r_integ_d, r_integ_q;
    logic [15:0] r_kp_d, r_ki_d, r_kp_q, r_ki_q;
    logic [11:0] r_thr;
    logic signed [48:0] r_ia, r_ibr, r_ib, r_id, r_iq, r_vd, r_vq;
    logic signed [66:0] r_acc;
    logic [47:0] r_num, r_quo;
    logic        r_neg;
    logic        r_sat;
    logic signed [31:0] r_va, r_vb;
    logic        r_valid;

    // Multiplier operands.
    logic signed [48:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [66:0] mul_p;
    logic signed [17:0] cs, sn;
    logic signed [48:0] vq_mag;

    assign cs     = cos_of(r_sector);
    assign sn     = sin_of(r_sector);
    assign vq_mag = r_vq[48] ? -r_vq : r_vq;

    hsfoc_mac u_mac (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Operand select: a product issued in one state lands in the next state.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_IB:  begin mul_a = r_ibr; mul_b = $signed({2'b0, INV_SQRT3_Q16}); end
            S_ID0: begin mul_a = r_ia; mul_b = cs; end
            S_ID1: begin mul_a = r_ib; mul_b = sn; end
            S_IQ0: begin mul_a = r_ib; mul_b = cs; end
            S_IQ1: begin mul_a = r_ia; mul_b = sn; end
            S_INT: begin mul_a = -r_id; mul_b = $signed({2'b0, r_kp_d}); end
            S_PD1: begin mul_a = {r_integ_d[47], r_integ_d}; mul_b = $signed({2'b0, r_ki_d}); end
            S_PQ0: begin mul_a = -r_iq; mul_b = $signed({2'b0, r_kp_q}); end
            S_PQ1: begin mul_a = {r_integ_q[47], r_integ_q}; mul_b = $signed({2'b0, r_ki_q}); end
            S_TH:  begin mul_a = vq_mag; mul_b = $signed({6'b0, r_thr}); end
            S_VA0: begin mul_a = r_vd; mul_b = cs; end
            S_VA1: begin mul_a = r_vq; mul_b = sn; end
            S_VB0: begin mul_a = r_vd; mul_b = sn; end
            S_VB1: begin mul_a = r_vq; mul_b = cs; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Rounding by 2^16, half toward plus infinity.
    function automatic logic signed [66:0] rs16(input logic signed [66:0] x);
        return (x + 67'sd32768) >>> 16;
    endfunction

    function automatic logic signed [47:0] iclamp(input logic signed [48:0] x);
        logic signed [47:0] r;
        if (x > INTEG_MAX)      r = INTEG_MAX[47:0];
        else if (x < INTEG_MIN) r = INTEG_MIN[47:0];
        else                    r = x[47:0];
        return r;
    endfunction

    // Helpers on the running product.
    logic signed [66:0] rnd_p, rnd_add, rnd_sub;
    logic signed [48:0] integ_next_d, integ_next_q;
    logic               integ_over;
    logic [CURRENT_BITS+1:0] ab_sum;
    always_comb begin
        rnd_p        = rs16(mul_p);
        rnd_add      = rs16(r_acc + mul_p);
        rnd_sub      = rs16(r_acc - mul_p);
        integ_next_d = {r_integ_d[47], r_integ_d} - r_id;
        integ_next_q = {r_integ_q[47], r_integ_q} - r_iq;
        integ_over   = (integ_next_d > INTEG_MAX) || (integ_next_d < INTEG_MIN) ||
                       (integ_next_q > INTEG_MAX) || (integ_next_q < INTEG_MIN);
        ab_sum       = {2'b0, i_phase_a_current} + {1'b0, i_phase_b_current, 1'b0};
    end

    // Division by 4095 with rounding: a shift-add estimate that is at most one
    // low, then one compare-subtract step.
    logic [47:0] num, num_sum, est, rem, qfin;
    always_comb begin
        num     = mul_p[47:0] + 48'(THROTTLE_HALF);
        num_sum = num + (num >> 12) + (num >> 24) + (num >> 36);
        est     = num_sum >> 12;
        rem     = r_num - (r_quo << 12) + r_quo;
        qfin    = (rem >= 48'(THROTTLE_FULL)) ? r_quo + 48'd1 : r_quo;
    end

    // Clamp to the signed 32-bit range.
    logic signed [66:0] vclamp_in;
    logic signed [31:0] sat32;
    logic                sat32_f;
    always_comb begin
        unique case (r_state)
            S_PQ0, S_VQ: vclamp_in = r_acc + rnd_p;
            S_VB0:       vclamp_in = rnd_sub;
            default:     vclamp_in = rnd_add;
        endcase
        if (vclamp_in > V_MAX) begin
            sat32 = 32'h7fffffff; sat32_f = 1'b1;
        end else if (vclamp_in < V_MIN) begin
            sat32 = 32'h80000000; sat32_f = 1'b1;
        end else begin
            sat32 = vclamp_in[31:0]; sat32_f = 1'b0;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_IB;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = (r_state < S_OUT) ? r_state + 5'd1 : S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sector  <= 3'd0;
            r_integ_d <= '0;
            r_integ_q <= '0;
            r_kp_d    <= 16'd6554;
            r_ki_d    <= 16'd655;
            r_kp_q    <= 16'd6554;
            r_ki_q    <= 16'd655;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_KP_D: r_kp_d <= i_cfg_data;
                    REG_KI_D: r_ki_d <= i_cfg_data;
                    REG_KP_Q: r_kp_q <= i_cfg_data;
                    REG_KI_Q: r_ki_q <= i_cfg_data;
                endcase
            end
            if (r_state == S_IDLE && i_valid && hall_to_sector(i_hall_code) != SECTOR_KEEP)
                r_sector <= hall_to_sector(i_hall_code);
            if (r_state == S_INT) begin
                r_integ_d <= iclamp(integ_next_d);
                r_integ_q <= iclamp(integ_next_q);
            end
            if (r_state == S_FIN) r_valid <= 1'b1;
            else if (r_state == S_OUT && i_ready) r_valid <= 1'b0;
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_ia  <= {{(49 - CURRENT_BITS - FRAC_BITS){1'b0}},
                              i_phase_a_current, {FRAC_BITS{1'b0}}};
                    r_ibr <= {{(49 - CURRENT_BITS - 2 - FRAC_BITS){1'b0}},
                              ab_sum, {FRAC_BITS{1'b0}}};
                    r_thr <= i_throttle_count;
                    r_sat <= 1'b0;
                end
            end
            S_ID0: r_ib  <= rnd_p[48:0];
            S_ID1: r_acc <= mul_p;
            S_IQ0: r_id  <= rnd_add[48:0];
            S_IQ1: r_acc <= mul_p;
            S_EQ:  r_iq  <= rnd_sub[48:0];
            S_INT: r_sat <= r_sat | integ_over;
            S_PD1: r_acc <= rnd_p;
            S_PQ0: begin
                r_vd  <= {{17{sat32[31]}}, sat32};
                r_sat <= r_sat | sat32_f;
            end
            S_PQ1: r_acc <= rnd_p;
            S_VQ: begin
                r_vq  <= {{17{sat32[31]}}, sat32};
                r_sat <= r_sat | sat32_f;
            end
            S_TH:  r_neg <= r_vq[48];
            S_DV0: begin
                r_num <= num;
                r_quo <= est;
            end
            S_DV1: r_vq <= r_neg ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});
            S_VA1: r_acc <= mul_p;
            S_VB0: begin
                r_va  <= sat32;
                r_sat <= r_sat | sat32_f;
            end
            S_VB1: r_acc <= mul_p;
            S_FIN: begin
                r_vb  <= sat32;
                r_sat <= r_sat | sat32_f;
            end
            default: ;
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_valid;
    assign o_v_alpha   = r_va;
    assign o_v_beta    = r_vb;
    assign o_saturated = r_sat;

endmodule

[rtl/core/hsfoc_checker.sv]
module hsfoc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_v_alpha
);

    // Never accepting a new item while a result is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");

    // A result stays until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_v_alpha))
        else $error("result dropped");

    // An accepted item drops ready the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("ready after accept");

endmodule

bind hall_sector_foc_current_loop hsfoc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_v_alpha(o_v_alpha)
);
